// ===== hw/rtl/lfe_pkg.sv =====
package lfe_pkg;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int FRAMES_W   = 21;
  localparam int FRAME_POS_W = 20;
  localparam int CHANNELS_W = 6;
  localparam int CHAN_POS_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  // Arithmetic widths: product mag*num, then 2*product + den
  localparam int PROD_W     = SAMPLE_W + FRAME_POS_W;
  localparam int DIVIDEND_W = PROD_W + 1;
  localparam int DIVISOR_W  = FRAME_POS_W + 1;
  localparam int STEP_W     = 4;

  // Register limits
  localparam logic [FRAMES_W-1:0]   MAX_FRAMES   = 21'd1048576;
  localparam logic [CHANNELS_W-1:0] MAX_CHANNELS = 6'd32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN      = 2'd2;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

endpackage

// ===== hw/rtl/lfe_if.sv =====
// Sample request channel into the fader
interface lfe_in_if import lfe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// Scaled sample request channel out of the fader
interface lfe_out_if import lfe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       range_end;

  modport source (output valid, output sample_out, output range_end, input ready);
  modport sink   (input valid, input sample_out, input range_end, output ready);
endinterface

// ===== hw/rtl/linear_fade_envelope.sv =====
// Linear fade-in / fade-out over one range of interleaved audio frames.
// in_ch carries one signed Q1.15 sample per request, frame by frame and
// channel by channel. out_ch returns the sample scaled by
// frame/(N-1) (fade-in) or (N-1-frame)/(N-1) (fade-out), rounded to
// nearest with ties away from zero; range_end flags the last sample.
// The cfg port writes range_frames (0), channels (1) and fade_in (2);
// any write restarts the range at frame 0, channel 0.
// From acceptance to the output register each sample goes through a
// bit-serial multiply, the forming of the rounded dividend, a
// restoring division and a delivery step.
// The shared shift-add unit handles one sample at a time, so the block
// takes no new sample until the last one is in the output register.
// With range_frames at zero a sample is accepted and dropped.
// The output register frees the input side: a new sample is accepted
// while a finished result still waits. If the receiver stalls longer,
// the next result waits in its last step until the register drains.
// Reset returns range_frames 0, channels 1, fade_in 1 and clears both
// counters and the output valid flag.
module linear_fade_envelope import lfe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lfe_in_if.sink                in_ch,
  lfe_out_if.source             out_ch
);

  // Configuration and position registers
  logic [FRAMES_W-1:0]    range_frames_r, range_frames_nxt;
  logic [CHANNELS_W-1:0]  channels_r, channels_nxt;
  logic                   fade_in_r, fade_in_nxt;
  logic [FRAME_POS_W-1:0] frame_pos_r, frame_pos_nxt;
  logic [CHAN_POS_W-1:0]  chan_pos_r, chan_pos_nxt;

  // Datapath registers
  state_t                 state_r, state_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [PROD_W-1:0]      acc_r, acc_nxt;
  logic [SAMPLE_W-1:0]    sh_r, sh_nxt;
  logic [FRAME_POS_W-1:0] num_r, num_nxt;
  logic [DIVISOR_W-1:0]   dv_r, dv_nxt;
  logic [DIVISOR_W-1:0]   rem_r, rem_nxt;
  logic                   neg_r, neg_nxt;
  logic                   zero_r, zero_nxt;
  logic                   end_r, end_nxt;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]    out_sample_r, out_sample_nxt;
  logic                   out_end_r, out_end_nxt;

  // Effective register values
  logic [FRAMES_W-1:0]    n_eff;
  logic [FRAMES_W-1:0]    n_minus1;
  logic [FRAME_POS_W-1:0] den;
  logic [CHANNELS_W-1:0]  ch_eff;

  logic                   in_acc;
  logic                   last_ch, last_fr;
  logic [SAMPLE_W-1:0]    raw, mag;
  logic [PROD_W-1:0]      addend;
  logic [DIVIDEND_W-1:0]  dividend;
  logic [DIVISOR_W:0]     trial, diff;
  logic                   ge;
  logic [SAMPLE_W-1:0]    quot, result;
  logic                   out_free;

  assign n_eff    = (range_frames_r > MAX_FRAMES) ? MAX_FRAMES : range_frames_r;
  assign n_minus1 = n_eff - FRAMES_W'(1);
  assign den      = n_minus1[FRAME_POS_W-1:0];
  always_comb begin
    if (channels_r == '0) begin
      ch_eff = CHANNELS_W'(1);
    end else if (channels_r > MAX_CHANNELS) begin
      ch_eff = MAX_CHANNELS;
    end else begin
      ch_eff = channels_r;
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Position wrap
  assign last_ch = ({1'b0, chan_pos_r} + CHANNELS_W'(1)) >= ch_eff;
  assign last_fr = (frame_pos_r == den);

  // Sign and magnitude of the incoming sample
  assign raw = in_ch.sample_in;
  assign mag = raw[SAMPLE_W-1] ? (SAMPLE_W'(0) - raw) : raw;

  // Shift-add multiply step, dividend forming, restoring divide step
  assign addend   = sh_r[SAMPLE_W-1] ? PROD_W'(num_r) : '0;
  assign dividend = {acc_r, 1'b0} + DIVIDEND_W'(dv_r[DIVISOR_W-1:1]);
  assign trial    = {rem_r, sh_r[SAMPLE_W-1]};
  assign diff     = trial - {1'b0, dv_r};
  assign ge       = (trial >= {1'b0, dv_r});

  assign quot     = zero_r ? '0 : sh_r;
  assign result   = neg_r ? (SAMPLE_W'(0) - quot) : quot;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    range_frames_nxt = range_frames_r;
    channels_nxt     = channels_r;
    fade_in_nxt      = fade_in_r;
    frame_pos_nxt    = frame_pos_r;
    chan_pos_nxt     = chan_pos_r;
    state_nxt        = state_r;
    step_nxt         = step_r;
    acc_nxt          = acc_r;
    sh_nxt           = sh_r;
    num_nxt          = num_r;
    dv_nxt           = dv_r;
    rem_nxt          = rem_r;
    neg_nxt          = neg_r;
    zero_nxt         = zero_r;
    end_nxt          = end_r;
    out_valid_nxt    = out_valid_r;
    out_sample_nxt   = out_sample_r;
    out_end_nxt      = out_end_r;

    // Drain the output register
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && n_eff != '0) begin
          neg_nxt  = raw[SAMPLE_W-1];
          sh_nxt   = mag;
          num_nxt  = fade_in_r ? frame_pos_r : (den - frame_pos_r);
          dv_nxt   = {den, 1'b0};
          zero_nxt = (n_eff == FRAMES_W'(1));
          end_nxt  = last_ch && last_fr;
          acc_nxt  = '0;
          step_nxt = '0;
          state_nxt = ST_MUL;
          if (last_ch) begin
            chan_pos_nxt  = '0;
            frame_pos_nxt = last_fr ? '0 : (frame_pos_r + FRAME_POS_W'(1));
          end else begin
            chan_pos_nxt = chan_pos_r + CHAN_POS_W'(1);
          end
        end
      end
      ST_MUL: begin
        acc_nxt  = {acc_r[PROD_W-2:0], 1'b0} + addend;
        sh_nxt   = {sh_r[SAMPLE_W-2:0], 1'b0};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == '1) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        // Add den for round-half-up on the magnitude
        rem_nxt   = dividend[DIVIDEND_W-1:SAMPLE_W];
        sh_nxt    = dividend[SAMPLE_W-1:0];
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        sh_nxt   = {sh_r[SAMPLE_W-2:0], ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == '1) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = result;
          out_end_nxt    = end_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Register writes restart the range
    if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE_FRAMES: begin
          range_frames_nxt = cfg_data[FRAMES_W-1:0];
          frame_pos_nxt    = '0;
          chan_pos_nxt     = '0;
        end
        CFG_CHANNELS: begin
          channels_nxt  = cfg_data[CHANNELS_W-1:0];
          frame_pos_nxt = '0;
          chan_pos_nxt  = '0;
        end
        CFG_FADE_IN: begin
          fade_in_nxt   = cfg_data[0];
          frame_pos_nxt = '0;
          chan_pos_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_frames_r <= '0;
      channels_r     <= CHANNELS_W'(1);
      fade_in_r      <= 1'b1;
      frame_pos_r    <= '0;
      chan_pos_r     <= '0;
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
    end else begin
      range_frames_r <= range_frames_nxt;
      channels_r     <= channels_nxt;
      fade_in_r      <= fade_in_nxt;
      frame_pos_r    <= frame_pos_nxt;
      chan_pos_r     <= chan_pos_nxt;
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    acc_r        <= acc_nxt;
    sh_r         <= sh_nxt;
    num_r        <= num_nxt;
    dv_r         <= dv_nxt;
    rem_r        <= rem_nxt;
    neg_r        <= neg_nxt;
    zero_r       <= zero_nxt;
    end_r        <= end_nxt;
    out_sample_r <= out_sample_nxt;
    out_end_r    <= out_end_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.range_end  = out_end_r;

  // Counters stay inside the range
  a_frame_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (n_eff != '0) |-> (frame_pos_r <= den))
    else $error("frame position beyond range");

  a_chan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, chan_pos_r} < ch_eff))
    else $error("channel position beyond frame");

  // Flagged last sample wraps both counters
  a_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && n_eff != '0 && last_ch && last_fr && !cfg_we)
      |=> (frame_pos_r == '0 && chan_pos_r == '0))
    else $error("counters did not wrap after range end");

  // Partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && !zero_r) |-> (rem_r < dv_r))
    else $error("divide remainder out of bound");

  // Divide always starts from step zero
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PREP) |=> (state_r == ST_DIV && step_r == '0))
    else $error("divide entered with stale step count");

endmodule
